>>> hw/rtl/size_class_block_allocator_macros.svh
// Assertion macros shared by the size-class allocator RTL.
// Standalone header; the modules that check their own logic include it.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SCA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SCA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sca_pkg.sv
// Package for the size-class block allocator: sizes, beat structs, codes
// and helper functions. No dependencies.
package sca_pkg;

   localparam int NUM_CLASSES        = 9;
   localparam int BLOCKS_PER_CLASS   = 256;
   localparam int LARGE_CLASS_BLOCKS = 64;
   localparam int MIN_BLOCK_BYTES    = 16;
   localparam int ROW_DEPTH          = 256;
   localparam int LARGE_CLASS_ID     = 8;

   localparam int CLS_W   = 4;
   localparam int PTR_W   = 8;
   localparam int CNT_W   = 9;
   localparam int SIZE_W  = 16;
   localparam int GRANT_W = 13;
   localparam int CIDX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int ADDR_W  = $clog2(NUM_CLASSES * ROW_DEPTH);

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOO_LARGE   = 3'd1,
      ST_CLASS_EMPTY = 3'd2,
      ST_BAD_SIZE    = 3'd3,
      ST_LIST_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      logic              req_type;
      logic [SIZE_W-1:0] size_bytes;
      logic [PTR_W-1:0]  block_index;
   } req_beat_type;

   typedef struct packed {
      status_type         status;
      logic [CLS_W-1:0]   class_index;
      logic [GRANT_W-1:0] granted_bytes;
      logic [PTR_W-1:0]   alloc_index;
   } rsp_beat_type;

   // One access to the free-list memory.
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [PTR_W-1:0]  wr_data;
   } mem_cmd_type;

   // Everything of a result except the block index read from memory.
   typedef struct packed {
      status_type         status;
      logic [CLS_W-1:0]   class_index;
      logic [GRANT_W-1:0] granted_bytes;
      logic               use_mem;
      logic               written;
      logic [PTR_W-1:0]   pos;
   } result_info_type;

   function automatic logic [CNT_W-1:0] class_cap(input logic [CLS_W-1:0] c);
      return (c == CLS_W'(LARGE_CLASS_ID)) ? CNT_W'(LARGE_CLASS_BLOCKS)
                                           : CNT_W'(BLOCKS_PER_CLASS);
   endfunction

   function automatic logic [GRANT_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
      return GRANT_W'(MIN_BLOCK_BYTES) << c;
   endfunction

endpackage

>>> hw/rtl/sca_list_ram.sv
// Free-list storage: one row of block indices per size class.
// Depends on sca_pkg for widths and the command struct.
module sca_list_ram
   import sca_pkg::*;
(
   input  logic             clock,
   input  mem_cmd_type      cmd,
   output logic [PTR_W-1:0] rd_data
);

   logic [PTR_W-1:0] mem [NUM_CLASSES*ROW_DEPTH];
   logic [PTR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sca_ptr_state.sv
// Class decode plus head, tail, free-count and fill-count registers per class.
// Depends on sca_pkg and the allocator assertion macros.
`include "size_class_block_allocator_macros.svh"

module sca_ptr_state
   import sca_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  req_beat_type    req,
   output mem_cmd_type     cmd,
   output result_info_type info
);

   logic [PTR_W-1:0] head_ff  [NUM_CLASSES];
   logic [PTR_W-1:0] tail_ff  [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] fill_ff  [NUM_CLASSES];

   logic [PTR_W-1:0]  head_in;
   logic [PTR_W-1:0]  tail_in;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  fill_in;
   logic              upd_alloc;
   logic              upd_free;
   logic              found;
   logic [CLS_W-1:0]  cls;
   logic [CIDX_W-1:0] ci;

   // Smallest class that fits (alloc) or exactly matches (free).
   always_comb begin
      found = 1'b0;
      cls   = '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         if (!found) begin
            if (req.req_type == REQ_ALLOC) begin
               if (req.size_bytes <= SIZE_W'(class_bytes(CLS_W'(k)))) begin
                  found = 1'b1;
                  cls   = CLS_W'(k);
               end
            end else if (req.size_bytes == SIZE_W'(class_bytes(CLS_W'(k)))) begin
               found = 1'b1;
               cls   = CLS_W'(k);
            end
         end
      end
   end

   assign ci = cls[CIDX_W-1:0];

   always_comb begin
      logic [CNT_W-1:0] cap;
      logic [PTR_W-1:0] head;
      logic [PTR_W-1:0] tail;
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] fill;
      cap  = class_cap(cls);
      head = head_ff[ci];
      tail = tail_ff[ci];
      cnt  = count_ff[ci];
      fill = fill_ff[ci];

      info               = '0;
      info.status        = ST_OK;
      cmd                = '0;
      upd_alloc          = 1'b0;
      upd_free           = 1'b0;
      head_in  = ({1'b0, head} == cap - 1'b1) ? '0 : head + 1'b1;
      tail_in  = ({1'b0, tail} == cap - 1'b1) ? '0 : tail + 1'b1;
      count_in = cnt;
      fill_in  = (fill < cap) ? fill + 1'b1 : fill;

      if (!found) begin
         info.status = (req.req_type == REQ_ALLOC) ? ST_TOO_LARGE : ST_BAD_SIZE;
      end else if (req.req_type == REQ_ALLOC) begin
         info.class_index = cls;
         if (cnt == '0) begin
            info.status = ST_CLASS_EMPTY;
         end else begin
            upd_alloc          = 1'b1;
            count_in           = cnt - 1'b1;
            info.granted_bytes = class_bytes(cls);
            info.use_mem       = 1'b1;
            // A slot the tail never reached is unwritten and reads as its reset index.
            info.written       = ({1'b0, head} < fill);
            info.pos           = head;
            cmd.addr           = ADDR_W'({cls, head});
         end
      end else begin
         info.class_index = cls;
         if (cnt >= cap) begin
            info.status = ST_LIST_FULL;
         end else begin
            upd_free           = 1'b1;
            count_in           = cnt + 1'b1;
            info.granted_bytes = class_bytes(cls);
            cmd.addr           = ADDR_W'({cls, tail});
            cmd.wr_data        = req.block_index;
         end
      end
      cmd.rd_en = advance && upd_alloc;
      cmd.wr_en = advance && upd_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            head_ff[k]  <= '0;
            tail_ff[k]  <= '0;
            count_ff[k] <= class_cap(CLS_W'(k));
            fill_ff[k]  <= '0;
         end
      end else if (advance) begin
         if (upd_alloc) begin
            head_ff[ci]  <= head_in;
            count_ff[ci] <= count_in;
         end
         if (upd_free) begin
            tail_ff[ci]  <= tail_in;
            count_ff[ci] <= count_in;
            fill_ff[ci]  <= fill_in;
         end
      end
   end

   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_chk
      `SCA_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff[g] <= class_cap(CLS_W'(g)), "free count above class capacity")
      `SCA_ASSERT_IMP(a_fill_cap, clock, reset, 1'b1, fill_ff[g] <= class_cap(CLS_W'(g)), "fill count above class capacity")
   end
   `SCA_ASSERT_IMP(a_one_access, clock, reset, 1'b1, $onehot0({cmd.rd_en, cmd.wr_en}), "read and write issued together")

endmodule

>>> hw/rtl/size_class_block_allocator.sv
// Size-class block allocator with nine power-of-two free-list classes.
// A request beat is held first in the request register, then in the response register that drives the response beat.
// Throughput: one request per cycle while responses are taken; the per-class pointer update is a single pass.
// The response register lets the next request enter while a response waits.
// Reset is synchronous and active high; the block takes requests at once after it.
// Unwritten list slots read as their reset index through per-class fill counts.
`include "size_class_block_allocator_macros.svh"

module size_class_block_allocator
   import sca_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   // The request register holds one beat. It moves on whenever the response
   // register is empty or its beat is being taken in the same cycle.
   logic            s1_valid_ff;
   req_beat_type    req_ff;
   logic            s1_adv;
   logic            s2_valid_ff;
   result_info_type info_ff;
   result_info_type info;
   mem_cmd_type     cmd;
   logic [PTR_W-1:0] rd_data;

   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (!s2_valid_ff || rsp_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_beat;
      end
      if (s1_adv) begin
         info_ff <= info;
      end
   end

   // Decode and the per-class pointers act on the registered request; the
   // state is updated only in the cycle the beat moves to the response stage.
   sca_ptr_state u_ptr (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_adv),
      .req     (req_ff),
      .cmd     (cmd),
      .info    (info)
   );

   // The read data is registered inside the memory, so it lines up with the
   // response register. A write from one beat is visible to a read by the next.
   sca_list_ram u_ram (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   // A slot that the tail never reached has not been written; it reads as its reset
   // value, which is its own position within the class.
   always_comb begin
      rsp_beat.status        = info_ff.status;
      rsp_beat.class_index   = info_ff.class_index;
      rsp_beat.granted_bytes = info_ff.granted_bytes;
      if (!info_ff.use_mem) begin
         rsp_beat.alloc_index = '0;
      end else if (info_ff.written) begin
         rsp_beat.alloc_index = rd_data;
      end else begin
         rsp_beat.alloc_index = info_ff.pos;
      end
   end

   assign rsp_valid = s2_valid_ff;

   `SCA_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(req_ff), "stalled request lost")
   `SCA_ASSERT_IMP(a_ok_grant, clock, reset, rsp_valid && rsp_beat.status == ST_OK, rsp_beat.granted_bytes != '0, "ok response without a granted size")

endmodule
